// File: rtl/info_frame_receiver_core_defines.svh
// assertion macros shared by the receiver rtl files
// no dependencies; included inside module bodies that assert
`ifndef INFO_FRAME_RECEIVER_CORE_DEFINES_SVH
`define INFO_FRAME_RECEIVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during reset
`define IFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receiver assertion failed");
// next-cycle implication, checked on clk, off during reset
`define IFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receiver assertion failed");
`else
`define IFR_ASSERT_IMP(lbl, ante, cons)
`define IFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/ifr_pkg.sv
// types, byte codes and helpers of the info frame receiver
// no dependencies; used by ifr_parser, ifr_result_fifo and the top level
package ifr_pkg;

    // line codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] CTRL_I0   = 8'h00;
    localparam logic [7:0] CTRL_I1   = 8'h40;
    localparam logic [7:0] CTRL_DISC = 8'h07;
    localparam logic [7:0] RR_BASE   = 8'h05;
    localparam logic [7:0] REJ_BASE  = 8'h01;
    localparam logic [7:0] ADDR_RESET = 8'h03;

    // frame parser states
    typedef enum logic [2:0] {
        PS_HUNT = 3'd0,
        PS_FLAG = 3'd1,
        PS_ADDR = 3'd2,
        PS_CTRL = 3'd3,
        PS_DATA = 3'd4,
        PS_ESC  = 3'd5
    } parse_state_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD     = 2'd0,
        KIND_GOOD        = 2'd1,
        KIND_CHECK_ERROR = 2'd2,
        KIND_DISCONNECT  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] reply_control;
        logic       last;
    } result_t;

    // up to two results from one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

    function automatic result_t make_result(kind_t k, logic [7:0] d, logic [7:0] r);
        result_t res;
        res.kind          = k;
        res.data_byte     = d;
        res.reply_control = r;
        res.last          = 1'b0;
        return res;
    endfunction

endpackage

// File: rtl/ifr_parser.sv
// frame parser: flag, address, control, header check, de-stuffing, bcc2
// depends on ifr_pkg; state advances once per byte on step_en
module ifr_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    rx_address,
    output ifr_pkg::step_t step_out
);
    import ifr_pkg::*;

    parse_state_t state_reg, state_next;
    logic [7:0]   control_byte_reg, control_byte_next;
    logic [7:0]   held_byte_reg, held_byte_next;
    logic         held_valid_reg, held_valid_next;
    logic [7:0]   check_reg, check_next;
    logic         rx_sequence_reg, rx_sequence_next;
    step_t        so;

    // next state and results for the current byte
    always_comb
    begin
        state_next        = state_reg;
        control_byte_next = control_byte_reg;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg;
        check_next        = check_reg;
        rx_sequence_next  = rx_sequence_reg;
        so                = '0;
        case (state_reg)
            PS_FLAG:
            begin
                if (rx_byte == rx_address)
                    state_next = PS_ADDR;
                else if (rx_byte != FLAG_BYTE)
                    state_next = PS_HUNT;
            end
            PS_ADDR:
            begin
                if (rx_byte == CTRL_I0 || rx_byte == CTRL_I1)
                begin
                    control_byte_next = rx_byte;
                    state_next        = PS_CTRL;
                end
                else if (rx_byte == FLAG_BYTE)
                    state_next = PS_FLAG;
                else if (rx_byte == CTRL_DISC)
                begin
                    so.count   = 2'd1;
                    so.res0    = make_result(KIND_DISCONNECT, 8'h00, CTRL_DISC);
                    state_next = PS_HUNT;
                end
                else
                    state_next = PS_HUNT;
            end
            PS_CTRL:
            begin
                if (rx_byte == (rx_address ^ control_byte_reg))
                begin
                    state_next      = PS_DATA;
                    held_valid_next = 1'b0;
                    held_byte_next  = 8'h00;
                    check_next      = 8'h00;
                end
                else if (rx_byte == FLAG_BYTE)
                    state_next = PS_FLAG;
                else
                    state_next = PS_HUNT;
            end
            PS_DATA:
            begin
                if (rx_byte == ESC_BYTE)
                    state_next = PS_ESC;
                else if (rx_byte == FLAG_BYTE)
                begin
                    // closing flag: held byte is bcc2
                    so.count = 2'd1;
                    if (held_valid_reg && held_byte_reg == check_reg)
                    begin
                        so.res0 = make_result(KIND_GOOD, 8'h00,
                                              {rx_sequence_reg, RR_BASE[6:0]});
                        rx_sequence_next = !rx_sequence_reg;
                    end
                    else
                        so.res0 = make_result(KIND_CHECK_ERROR, 8'h00,
                                              {rx_sequence_reg, REJ_BASE[6:0]});
                    held_valid_next = 1'b0;
                    state_next      = PS_HUNT;
                end
                else
                begin
                    if (held_valid_reg)
                    begin
                        so.count   = 2'd1;
                        so.res0    = make_result(KIND_PAYLOAD, held_byte_reg, 8'h00);
                        check_next = check_reg ^ held_byte_reg;
                    end
                    held_byte_next  = rx_byte;
                    held_valid_next = 1'b1;
                end
            end
            PS_ESC:
            begin
                state_next = PS_DATA;
                if (rx_byte == ESC_BYTE || rx_byte == FLAG_BYTE)
                begin
                    if (held_valid_reg)
                    begin
                        so.count   = 2'd1;
                        so.res0    = make_result(KIND_PAYLOAD, held_byte_reg, 8'h00);
                        check_next = check_reg ^ held_byte_reg;
                    end
                end
                else
                begin
                    // escape before an ordinary byte: both bytes are payload
                    if (held_valid_reg)
                    begin
                        so.count   = 2'd2;
                        so.res0    = make_result(KIND_PAYLOAD, held_byte_reg, 8'h00);
                        so.res1    = make_result(KIND_PAYLOAD, ESC_BYTE, 8'h00);
                        check_next = check_reg ^ held_byte_reg ^ ESC_BYTE;
                    end
                    else
                    begin
                        so.count   = 2'd1;
                        so.res0    = make_result(KIND_PAYLOAD, ESC_BYTE, 8'h00);
                        check_next = check_reg ^ ESC_BYTE;
                    end
                end
                held_byte_next  = rx_byte;
                held_valid_next = 1'b1;
            end
            default:
            begin
                if (rx_byte == FLAG_BYTE)
                    state_next = PS_FLAG;
                else
                    state_next = PS_HUNT;
            end
        endcase
        // mark the final result of this byte
        if (so.count == 2'd1)
            so.res0.last = 1'b1;
        if (so.count == 2'd2)
            so.res1.last = 1'b1;
    end

    assign step_out = so;

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= PS_HUNT;
            control_byte_reg <= 8'h00;
            held_byte_reg    <= 8'h00;
            held_valid_reg   <= 1'b0;
            check_reg        <= 8'h00;
            rx_sequence_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            state_reg        <= state_next;
            control_byte_reg <= control_byte_next;
            held_byte_reg    <= held_byte_next;
            held_valid_reg   <= held_valid_next;
            check_reg        <= check_next;
            rx_sequence_reg  <= rx_sequence_next;
        end
    end

endmodule

// File: rtl/ifr_result_fifo.sv
// result queue: up to two items written per cycle, one read per cycle
// depends on ifr_pkg and the shared assertion macros
module ifr_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  ifr_pkg::result_t push_res0,
    input  ifr_pkg::result_t push_res1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output ifr_pkg::result_t out_res
);
    import ifr_pkg::*;
    `include "info_frame_receiver_core_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointer and fill bookkeeping
    always_comb
    begin
        pop         = (count_reg != '0) && out_ready;
        wr_ptr_p1   = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push_cnt == 2'd1)
            wr_ptr_next = wr_ptr_p1;
        else if (push_cnt == 2'd2)
            wr_ptr_next = ptr_inc(wr_ptr_p1);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;

    // storage write and head read
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_res0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_p1] <= push_res1;
    end

    assign out_res = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // checks
    `IFR_ASSERT_IMP(a_no_overflow, 1'b1, count_reg <= CNT_W'(DEPTH))
    `IFR_ASSERT_NEXT(a_push_nonempty, push_cnt != 2'd0, count_reg != '0)
    `IFR_ASSERT_NEXT(a_pop_only, pop && push_cnt == 2'd0, count_reg == $past(count_reg) - 1'b1)

endmodule

// File: rtl/info_frame_receiver_core.sv
// top level of the info frame receiver: input stage, parser, result queue
// depends on ifr_pkg, ifr_parser, ifr_result_fifo and the assertion macros
//
// usage
//   rx_byte items enter on in_valid/in_ready, one received line byte each.
//   results leave on out_valid/out_ready: kind, data_byte, reply_control and
//   last, where last marks the final result caused by one input byte.
//   a byte gives zero, one or two results; a payload byte leaves one byte
//   late, so the byte before the closing flag is kept back as bcc2.
//   rx_address is written on cfg_valid/cfg_ready (always ready); the user must
//   write it only while idle, the block itself does not enforce this.
//   an accepted byte is held in the input register and parsed once the result
//   queue has room for two results; its results are written into the queue
//   and offered from there on out_valid/out_ready.
//   throughput: one byte per cycle while the queue has room; the output side
//   moves one result per cycle while out_ready is high. the parser step is
//   combinational logic between the input register and the queue.
//   reset: parser hunts for a flag, receive sequence bit is one, rx_address
//   is 0x03, queue is empty.
//   a stalled receiver fills the queue and then drops in_ready; no result is
//   lost.
module info_frame_receiver_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] reply_control,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import ifr_pkg::*;
    `include "info_frame_receiver_core_defines.svh"

    logic [7:0] rx_address_reg;
    logic [7:0] byte_reg;
    logic       byte_valid_reg, byte_valid_next;
    logic       fifo_room;
    logic       stage_fire;
    step_t      step_out;
    logic [1:0] push_cnt;
    result_t    out_res;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_address_reg <= ADDR_RESET;
        else if (cfg_valid)
            rx_address_reg <= cfg_data;
    end

    // input stage handshake
    assign stage_fire      = byte_valid_reg && fifo_room;
    assign in_ready        = !byte_valid_reg || stage_fire;
    assign byte_valid_next = (in_valid && in_ready) || (byte_valid_reg && !stage_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else
            byte_valid_reg <= byte_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
    end

    // frame parser
    ifr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (stage_fire),
        .rx_byte    (byte_reg),
        .rx_address (rx_address_reg),
        .step_out   (step_out)
    );

    assign push_cnt = stage_fire ? step_out.count : 2'd0;

    // result queue
    ifr_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_res0 (step_out.res0),
        .push_res1 (step_out.res1),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign data_byte     = out_res.data_byte;
    assign reply_control = out_res.reply_control;
    assign last          = out_res.last;

    // checks
    `IFR_ASSERT_IMP(a_report_last, out_valid && kind != KIND_PAYLOAD, last == 1'b1)
    `IFR_ASSERT_IMP(a_payload_no_reply, out_valid && kind == KIND_PAYLOAD, reply_control == 8'h00)
    `IFR_ASSERT_NEXT(a_stage_hold, byte_valid_reg && !stage_fire, byte_valid_reg)

endmodule
